FILE: rtl/lszof_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lszof_pkg: shared types, constants and helper functions
// Register map, configuration record, zone flags and fixed-point helpers
// for the laser scan zone obstacle flags block.
// ----------------------------------------------------------------------------
package lszof_pkg;

  // fixed sizes of the point fields and of the zone counters
  localparam int MAX_POINTS = 4096;
  localparam int RANGE_BITS = 16;
  localparam int IDX_W      = 12;
  localparam int ANG_W      = 16;
  localparam int LIM_W      = 16;
  localparam int CNT_W      = 13;
  localparam int SIN_W      = 16;
  localparam int PROD_W     = RANGE_BITS + SIN_W + 1;
  localparam int Q14_SHIFT  = 14;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // pi in Q30 and one in Q30 for the quarter-wave series
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // reciprocal constants for division by three and by five
  localparam logic [15:0] RECIP3 = 16'hAAAB;
  localparam logic [15:0] RECIP5 = 16'hCCCD;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ANGLE_START    = 3'd0,
    REG_ANGLE_STEP     = 3'd1,
    REG_SCAN_POINTS    = 3'd2,
    REG_SIDE_WINDOW    = 3'd3,
    REG_LATERAL_LIMIT  = 3'd4,
    REG_FRONT_LIMIT    = 3'd5,
    REG_SIDE_COUNT_MIN = 3'd6
  } reg_index_t;

  // configuration record
  typedef struct packed {
    logic [ANG_W-1:0] angle_start;
    logic [ANG_W-1:0] angle_step;
    logic [CNT_W-1:0] scan_points;
    logic [CNT_W-1:0] side_window;
    logic [LIM_W-1:0] lateral_limit_mm;
    logic [LIM_W-1:0] front_limit_mm;
    logic [CNT_W-1:0] side_count_min;
  } cfg_t;

  // zone membership of one point, decided from its index
  typedef struct packed {
    logic left;
    logic right;
    logic front;
    logic last;
  } zone_t;

  // scan length clipped to the largest supported scan
  function automatic logic [CNT_W-1:0] cap_points(input logic [CNT_W-1:0] sp);
    if (int'(sp) < MAX_POINTS) begin
      return sp;
    end
    return CNT_W'(MAX_POINTS);
  endfunction

  // floor(v / 3), exact for all 14-bit v
  function automatic logic [CNT_W-1:0] div3(input logic [CNT_W:0] v);
    logic [CNT_W+16:0] prod;
    prod = (CNT_W+17)'(v) * (CNT_W+17)'(RECIP3);
    return prod[CNT_W+16:17];
  endfunction

  // floor(v / 5), exact for all 13-bit v
  function automatic logic [CNT_W-1:0] div5(input logic [CNT_W-1:0] v);
    logic [CNT_W+15:0] prod;
    prod = (CNT_W+16)'(v) * (CNT_W+16)'(RECIP5);
    return CNT_W'(prod[CNT_W+15:18]);
  endfunction

  // saturating counter step
  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c != COUNT_MAX) ? c + CNT_W'(1) : c;
  endfunction

  // sine of r/16384 quarter turns in Q14, evaluated at elaboration
  function automatic logic [14:0] quarter_sine(input logic [14:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (64'(r) * PI_Q30) >> 15;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + 64'd32768) >> 16;
    if (s > 64'd16384) begin
      s = 64'd16384;
    end
    return s[14:0];
  endfunction

endpackage

FILE: rtl/laser_scan_zone_obstacle_flags_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_scan_zone_obstacle_flags_unit: scan point zone obstacle flags
// Projects laser scan points through a sine table and raises left, right and
// front obstacle flags once per scan.
// ----------------------------------------------------------------------------
// Usage:
//   Scan points enter on the s_axis channel, one request per point: range in
//   mm and the point's index in the scan. Points with an index at or past the
//   scan length are dropped. When the point with the last index arrives, one
//   request with three flags leaves on the m_axis channel and the zone
//   counters start over; other points produce nothing.
//   Throughput is one point per cycle while m_axis does not stall. The path is
//   a five-register pipeline (input, angle and zone decode, sine lookup,
//   projection multiply, counters and result register), so the flags are
//   registered once the last point has passed through the earlier stages.
//   When m_axis stalls, the result register holds its flags and the four
//   earlier stages keep taking points until they are full.
//   Configuration is written through cfg_we / cfg_index / cfg_data while the
//   block is idle (a rule for the user, not enforced); an unknown index is ignored.
//   Reset (synchronous, active high) empties the pipeline, clears the
//   counters and loads the default configuration.
// ----------------------------------------------------------------------------
module laser_scan_zone_obstacle_flags_unit #(
  parameter int SINE_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // range_mm [15:0], point_index [27:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // left_blocked [0], right_blocked [1], front_blocked [2]
);

  localparam int CNT_W = lszof_pkg::CNT_W;

  lszof_pkg::cfg_t cfg;

  // pipeline stage registers
  logic                                v1, v2, v3, v4;
  logic [lszof_pkg::RANGE_BITS-1:0]    range1, range2, range3;
  logic [lszof_pkg::IDX_W-1:0]         idx1;
  logic [lszof_pkg::ANG_W-1:0]         angle2;
  lszof_pkg::zone_t                    zone2, zone3, zone4;
  logic signed [lszof_pkg::SIN_W-1:0]  sin3, cos3;
  logic signed [lszof_pkg::PROD_W-1:0] x4, y4;

  logic                                ld1, ld2, ld3, ld4;
  logic                                cnt_ready;
  logic [CNT_W-1:0]                    points;
  logic [CNT_W-1:0]                    third;
  logic [CNT_W-1:0]                    two_third;
  logic [CNT_W-1:0]                    idx_ext;
  logic                                in_scan;
  lszof_pkg::zone_t                    zone_c;
  logic [lszof_pkg::ANG_W-1:0]         angle_c;
  logic [lszof_pkg::ANG_W-1:0]         cos_angle;
  logic signed [lszof_pkg::SIN_W-1:0]  sin_c, cos_c;
  logic signed [lszof_pkg::PROD_W-1:0] x_c, y_c;
  logic [2:0]                          flags;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_start      <= 16'hC000;
      cfg.angle_step       <= 16'd91;
      cfg.scan_points      <= 13'd720;
      cfg.side_window      <= 13'd10;
      cfg.lateral_limit_mm <= 16'd250;
      cfg.front_limit_mm   <= 16'd400;
      cfg.side_count_min   <= 13'd3;
    end else if (cfg_we) begin
      case (lszof_pkg::reg_index_t'(cfg_index))
        lszof_pkg::REG_ANGLE_START:    cfg.angle_start      <= cfg_data;
        lszof_pkg::REG_ANGLE_STEP:     cfg.angle_step       <= cfg_data;
        lszof_pkg::REG_SCAN_POINTS:    cfg.scan_points      <= cfg_data[CNT_W-1:0];
        lszof_pkg::REG_SIDE_WINDOW:    cfg.side_window      <= cfg_data[CNT_W-1:0];
        lszof_pkg::REG_LATERAL_LIMIT:  cfg.lateral_limit_mm <= cfg_data;
        lszof_pkg::REG_FRONT_LIMIT:    cfg.front_limit_mm   <= cfg_data;
        lszof_pkg::REG_SIDE_COUNT_MIN: cfg.side_count_min   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage load enables, each stage moves when the next one frees up
  assign ld4 = !v4 || cnt_ready;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign s_axis_tready = ld1;

  // zone decode from the point index
  assign points    = lszof_pkg::cap_points(cfg.scan_points);
  assign third     = lszof_pkg::div3({1'b0, points});
  assign two_third = lszof_pkg::div3({points, 1'b0});
  assign idx_ext   = {1'b0, idx1};
  assign in_scan   = idx_ext < points;

  always_comb begin
    zone_c.left  = idx_ext < cfg.side_window;
    zone_c.right = (points - idx_ext) < cfg.side_window;
    zone_c.front = (idx_ext > third) && (idx_ext < two_third);
    zone_c.last  = idx_ext == (points - CNT_W'(1));
  end

  // point angle, modulo one turn
  assign angle_c = cfg.angle_start + lszof_pkg::ANG_W'(idx1) * cfg.angle_step;

  // sine and cosine lookups
  assign cos_angle = angle2 + 16'h4000;

  lszof_sine #(
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_sin (
    .angle(angle2),
    .value(sin_c)
  );

  lszof_sine #(
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_cos (
    .angle(cos_angle),
    .value(cos_c)
  );

  // projection into Q14 mm
  assign y_c = lszof_pkg::PROD_W'($signed({1'b0, range3})) * lszof_pkg::PROD_W'(sin3);
  assign x_c = lszof_pkg::PROD_W'($signed({1'b0, range3})) * lszof_pkg::PROD_W'(cos3);

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ld1) begin
        v1 <= s_axis_tvalid;
      end
      if (ld2) begin
        v2 <= v1 && in_scan;
      end
      if (ld3) begin
        v3 <= v2;
      end
      if (ld4) begin
        v4 <= v3;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (ld1 && s_axis_tvalid) begin
      range1 <= s_axis_tdata[lszof_pkg::RANGE_BITS-1:0];
      idx1   <= s_axis_tdata[16 +: lszof_pkg::IDX_W];
    end
    if (ld2 && v1) begin
      range2 <= range1;
      angle2 <= angle_c;
      zone2  <= zone_c;
    end
    if (ld3 && v2) begin
      range3 <= range2;
      sin3   <= sin_c;
      cos3   <= cos_c;
      zone3  <= zone2;
    end
    if (ld4 && v3) begin
      x4    <= x_c;
      y4    <= y_c;
      zone4 <= zone3;
    end
  end

  // counters and result register
  lszof_count u_count (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (v4),
    .in_ready (cnt_ready),
    .zone     (zone4),
    .x_q14    (x4),
    .y_q14    (y4),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .flags    (flags)
  );

  assign m_axis_tdata = {5'b0, flags};

endmodule

FILE: rtl/lszof_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lszof_sine: sine lookup from a quarter-wave table
// Maps a 16-bit binary angle to its Q14 sine through a constant quarter-wave
// table and quadrant symmetry. SINE_ENTRIES must be a power of two (not checked).
// ----------------------------------------------------------------------------
module lszof_sine #(
  parameter int SINE_ENTRIES = 1024
) (
  input  logic [lszof_pkg::ANG_W-1:0]        angle,
  output logic signed [lszof_pkg::SIN_W-1:0] value
);

  localparam int IDX_BITS = $clog2(SINE_ENTRIES);
  localparam int QB       = IDX_BITS - 2;
  localparam int QN       = SINE_ENTRIES / 4;
  localparam int STEP     = 65536 / SINE_ENTRIES;
  localparam logic [QB:0] QN_IDX = (QB+1)'(QN);

  logic [14:0]         qtab [QN+1];
  logic [IDX_BITS-1:0] idx;
  logic [1:0]          quad;
  logic [QB-1:0]       sub;
  logic [QB:0]         qidx;
  logic [14:0]         mag;

  // constant quarter-wave table, one entry past the quarter for the peak
  for (genvar m = 0; m <= QN; m++) begin : g_qtab
    localparam logic [14:0] QV = lszof_pkg::quarter_sine(15'(m * STEP));
    assign qtab[m] = QV;
  end

  // fold the full-circle index into the quarter table
  assign idx  = angle[lszof_pkg::ANG_W-1 -: IDX_BITS];
  assign quad = idx[IDX_BITS-1 -: 2];
  assign sub  = idx[QB-1:0];
  assign qidx = quad[0] ? (QN_IDX - {1'b0, sub}) : {1'b0, sub};
  assign mag  = qtab[qidx];

  // lower half circle is negative
  assign value = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

FILE: rtl/lszof_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lszof_count: zone counters and flag result register
// Compares the projected point against the zone limits, steps the saturating
// counters and, on the last point of a scan, registers the three flags.
// ----------------------------------------------------------------------------
module lszof_count (
  input  logic                                clk,
  input  logic                                rst,
  input  lszof_pkg::cfg_t                     cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lszof_pkg::zone_t                    zone,
  input  logic signed [lszof_pkg::PROD_W-1:0] x_q14,
  input  logic signed [lszof_pkg::PROD_W-1:0] y_q14,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          flags
);

  logic [lszof_pkg::CNT_W-1:0]        left_count;
  logic [lszof_pkg::CNT_W-1:0]        right_count;
  logic [lszof_pkg::CNT_W-1:0]        front_count;
  logic [lszof_pkg::CNT_W-1:0]        left_count_next;
  logic [lszof_pkg::CNT_W-1:0]        right_count_next;
  logic [lszof_pkg::CNT_W-1:0]        front_count_next;
  logic [lszof_pkg::CNT_W-1:0]        front_min;
  logic signed [lszof_pkg::PROD_W-1:0] lat_q14;
  logic signed [lszof_pkg::PROD_W-1:0] front_q14;
  logic                               hit_left;
  logic                               hit_right;
  logic                               hit_front;
  logic                               adv;

  // limits scaled to Q14 mm
  assign lat_q14 = $signed({{(lszof_pkg::PROD_W-lszof_pkg::LIM_W-lszof_pkg::Q14_SHIFT){1'b0}},
                            cfg.lateral_limit_mm, {lszof_pkg::Q14_SHIFT{1'b0}}});
  assign front_q14 = $signed({{(lszof_pkg::PROD_W-lszof_pkg::LIM_W-lszof_pkg::Q14_SHIFT){1'b0}},
                              cfg.front_limit_mm, {lszof_pkg::Q14_SHIFT{1'b0}}});
  assign front_min = lszof_pkg::div5(lszof_pkg::cap_points(cfg.scan_points));

  // zone hits
  assign hit_left  = zone.left && (y_q14 > -lat_q14);
  assign hit_right = zone.right && (y_q14 < lat_q14);
  assign hit_front = zone.front && (x_q14 < front_q14);

  assign in_ready = !out_valid || out_ready;
  assign adv      = in_valid && in_ready;

  // counter next values
  always_comb begin
    left_count_next  = hit_left ? lszof_pkg::bump(left_count) : left_count;
    right_count_next = hit_right ? lszof_pkg::bump(right_count) : right_count;
    front_count_next = hit_front ? lszof_pkg::bump(front_count) : front_count;
  end

  // counters and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
      front_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        if (zone.last) begin
          left_count  <= '0;
          right_count <= '0;
          front_count <= '0;
          out_valid   <= 1'b1;
        end else begin
          left_count  <= left_count_next;
          right_count <= right_count_next;
          front_count <= front_count_next;
        end
      end
    end
  end

  // flag payload
  always_ff @(posedge clk) begin
    if (adv && zone.last) begin
      flags <= {front_count_next >= front_min,
                right_count_next >= cfg.side_count_min,
                left_count_next >= cfg.side_count_min};
    end
  end

endmodule

FILE: verif/laser_scan_zone_obstacle_flags_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_scan_zone_obstacle_flags_unit_tb: zone flag checks per scan
// Streams scan points into the unit with random input gaps and result-side
// back-pressure, projects each point through a locally built sine table to
// predict the left, right and front flags of every completed scan, and compares
// each flag request that leaves the unit against the oldest prediction.
// ----------------------------------------------------------------------------
module laser_scan_zone_obstacle_flags_unit_tb;

  localparam int LUT_SIZE      = 1024;
  localparam int SETTLE        = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_POINTS = 1650;
  localparam int unsigned HIT_MAX = 8191;
  localparam longint unsigned PI_FIX  = 64'd3373259426;
  localparam longint unsigned ONE_FIX = 64'd1 << 30;
  localparam logic [2:0] NO_SUCH_REG = 3'd7;

  // flags of one scan, left in the lowest bit
  typedef struct packed {
    logic front;
    logic right;
    logic left;
  } zone_flags_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // range_mm [15:0], point_index [27:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // left_blocked [0], right_blocked [1], front_blocked [2]

  bit calm = 1'b0;
  int mismatches = 0;
  int cycles = 0;
  int counted_points = 0;

  // local copy of the unit's table, settings and zone counters
  int               sin_lut [LUT_SIZE];
  lszof_pkg::cfg_t  live_cfg;
  int unsigned      left_hits;
  int unsigned      right_hits;
  int unsigned      front_hits;
  zone_flags_t      expected_flags [$];

  laser_scan_zone_obstacle_flags_unit #(
    .SINE_ENTRIES(LUT_SIZE)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 30);
  end

  // compare each flag request with the oldest prediction
  always @(posedge clk) begin : check_flags
    zone_flags_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_flags.size() == 0) begin
        $error("unexpected flag request: tdata %b", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_flags.pop_front();
        if (m_axis_tdata[0] !== want.left) begin
          $error("left_blocked: expected %0d, got %0d", want.left, m_axis_tdata[0]);
          mismatches++;
        end
        if (m_axis_tdata[1] !== want.right) begin
          $error("right_blocked: expected %0d, got %0d", want.right, m_axis_tdata[1]);
          mismatches++;
        end
        if (m_axis_tdata[2] !== want.front) begin
          $error("front_blocked: expected %0d, got %0d", want.front, m_axis_tdata[2]);
          mismatches++;
        end
        if (m_axis_tdata[7:3] !== 5'd0) begin
          $error("tdata padding: expected 0, got %b", m_axis_tdata[7:3]);
          mismatches++;
        end
      end
    end
  end

  // quarter-wave sine in Q14 from a Q30 series
  function automatic int quarter_wave(input int unsigned r);
    longint unsigned rr;
    longint unsigned th;
    longint unsigned th2;
    longint unsigned acc;
    longint unsigned s;
    rr  = r;
    th  = (rr * PI_FIX) >> 15;
    th2 = (th * th) >> 30;
    acc = ONE_FIX - th2 / 72;
    acc = ONE_FIX - ((th2 * acc) >> 30) / 42;
    acc = ONE_FIX - ((th2 * acc) >> 30) / 20;
    acc = ONE_FIX - ((th2 * acc) >> 30) / 6;
    s   = (th * acc) >> 30;
    s   = (s + 32768) >> 16;
    if (s > 16384) begin
      s = 16384;
    end
    return int'(s);
  endfunction

  // full-circle table from quarter-wave symmetry
  function automatic void build_sine_lut();
    int unsigned a;
    int unsigned q;
    int unsigned r;
    int          v;
    for (int k = 0; k < LUT_SIZE; k++) begin
      a = (k * 65536 / LUT_SIZE) & 32'hFFFF;
      q = a >> 14;
      r = a & 32'h3FFF;
      v = ((q & 1) != 0) ? quarter_wave(16384 - r) : quarter_wave(r);
      sin_lut[k] = ((q & 2) != 0) ? -v : v;
    end
  endfunction

  function automatic int sine_at(input int unsigned ang);
    return sin_lut[((ang & 32'hFFFF) * LUT_SIZE) >> 16];
  endfunction

  function automatic int unsigned bump_hits(input int unsigned c);
    return (c < HIT_MAX) ? c + 1 : c;
  endfunction

  // zone counting for one accepted point, flags on the last index
  function automatic void project_point(input logic [15:0] rng, input logic [11:0] idx);
    int unsigned p;
    int unsigned i;
    int unsigned sw;
    int unsigned a0;
    int unsigned st;
    int unsigned ang;
    longint      rv;
    longint      x;
    longint      y;
    longint      lat;
    longint      fwd;
    zone_flags_t res;
    p = (live_cfg.scan_points < lszof_pkg::MAX_POINTS) ? live_cfg.scan_points :
        lszof_pkg::MAX_POINTS;
    i = idx;
    if (i >= p) begin
      return;
    end
    counted_points++;
    a0  = live_cfg.angle_start;
    st  = live_cfg.angle_step;
    ang = (a0 + i * st) & 32'hFFFF;
    rv  = rng;
    y   = rv * sine_at(ang);
    x   = rv * sine_at(ang + 16384);
    lat = live_cfg.lateral_limit_mm;
    lat = lat * 16384;
    fwd = live_cfg.front_limit_mm;
    fwd = fwd * 16384;
    sw  = live_cfg.side_window;
    if (i < sw && y > -lat) begin
      left_hits = bump_hits(left_hits);
    end
    if (p - i < sw && y < lat) begin
      right_hits = bump_hits(right_hits);
    end
    if (i > p / 3 && i < (2 * p) / 3 && x < fwd) begin
      front_hits = bump_hits(front_hits);
    end
    if (i == p - 1) begin
      res.left  = (left_hits >= live_cfg.side_count_min);
      res.right = (right_hits >= live_cfg.side_count_min);
      res.front = (front_hits >= p / 5);
      expected_flags.insert(expected_flags.size(), res);
      left_hits  = 0;
      right_hits = 0;
      front_hits = 0;
    end
  endfunction

  function automatic lszof_pkg::cfg_t make_cfg(input logic [15:0] as, input logic [15:0] st,
                                               input logic [12:0] sp, input logic [12:0] sw,
                                               input logic [15:0] lat, input logic [15:0] fr,
                                               input logic [12:0] scm);
    lszof_pkg::cfg_t c;
    c.angle_start      = as;
    c.angle_step       = st;
    c.scan_points      = sp;
    c.side_window      = sw;
    c.lateral_limit_mm = lat;
    c.front_limit_mm   = fr;
    c.side_count_min   = scm;
    return c;
  endfunction

  function automatic logic [15:0] reg_value(input lszof_pkg::cfg_t c,
                                            input lszof_pkg::reg_index_t r);
    case (r)
      lszof_pkg::REG_ANGLE_START:    return c.angle_start;
      lszof_pkg::REG_ANGLE_STEP:     return c.angle_step;
      lszof_pkg::REG_SCAN_POINTS:    return 16'(c.scan_points);
      lszof_pkg::REG_SIDE_WINDOW:    return 16'(c.side_window);
      lszof_pkg::REG_LATERAL_LIMIT:  return c.lateral_limit_mm;
      lszof_pkg::REG_FRONT_LIMIT:    return c.front_limit_mm;
      lszof_pkg::REG_SIDE_COUNT_MIN: return 16'(c.side_count_min);
      default:                       return '0;
    endcase
  endfunction

  // mirror of a register write, unknown indexes are dropped
  function automatic void store_reg(input logic [2:0] idx, input logic [15:0] v);
    case (idx)
      lszof_pkg::REG_ANGLE_START:    live_cfg.angle_start      = v;
      lszof_pkg::REG_ANGLE_STEP:     live_cfg.angle_step       = v;
      lszof_pkg::REG_SCAN_POINTS:    live_cfg.scan_points      = v[lszof_pkg::CNT_W-1:0];
      lszof_pkg::REG_SIDE_WINDOW:    live_cfg.side_window      = v[lszof_pkg::CNT_W-1:0];
      lszof_pkg::REG_LATERAL_LIMIT:  live_cfg.lateral_limit_mm = v;
      lszof_pkg::REG_FRONT_LIMIT:    live_cfg.front_limit_mm   = v;
      lszof_pkg::REG_SIDE_COUNT_MIN: live_cfg.side_count_min   = v[lszof_pkg::CNT_W-1:0];
      default: ;
    endcase
  endfunction

  // one write cycle, write enable left high for the caller to drop
  task automatic drive_reg(input logic [2:0] idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    store_reg(idx, v);
  endtask

  task automatic write_one(input logic [2:0] idx, input logic [15:0] v);
    drive_reg(idx, v);
    cfg_we <= 1'b0;
  endtask

  task automatic program_all(input lszof_pkg::cfg_t c);
    lszof_pkg::reg_index_t r;
    r = r.first();
    do begin
      drive_reg(r, reg_value(c, r));
      r = r.next();
    end while (r != r.first());
    cfg_we <= 1'b0;
  endtask

  // one point request, with random idle cycles ahead of it unless calm is set
  task automatic send_point(input logic [15:0] rng, input logic [11:0] idx);
    if (!calm) begin
      while ($urandom_range(0, 99) < 30) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, idx, rng};
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    project_point(rng, idx);
  endtask

  // drain every pending flag request and let the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_flags.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] random_range();
    if ($urandom_range(0, 1) == 0) begin
      return 16'($urandom());
    end
    return 16'($urandom_range(0, 1200));
  endfunction

  function automatic logic [15:0] random_limit();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom());
      default: return 16'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic lszof_pkg::cfg_t random_cfg();
    lszof_pkg::cfg_t c;
    int unsigned     p;
    c.angle_start = 16'($urandom());
    case ($urandom_range(0, 3))
      0:       c.angle_step = 16'h8000;
      1:       c.angle_step = 16'h7FFF;
      2:       c.angle_step = 16'($urandom_range(0, 400));
      default: c.angle_step = 16'($urandom());
    endcase
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       c.scan_points = 13'd4096;
        1:       c.scan_points = 13'd8191;
        2:       c.scan_points = 13'd4095;
        default: c.scan_points = 13'd3000;
      endcase
    end else begin
      c.scan_points = 13'($urandom_range(1, 40));
    end
    p = (c.scan_points < lszof_pkg::MAX_POINTS) ? c.scan_points : lszof_pkg::MAX_POINTS;
    case ($urandom_range(0, 7))
      0:       c.side_window = 13'd0;
      1:       c.side_window = 13'd4096;
      default: c.side_window = 13'($urandom_range(0, p / 2 + 2));
    endcase
    c.lateral_limit_mm = random_limit();
    c.front_limit_mm   = random_limit();
    case ($urandom_range(0, 9))
      0:       c.side_count_min = 13'd0;
      1:       c.side_count_min = 13'd4096;
      2:       c.side_count_min = 13'd8191;
      default: c.side_count_min = 13'($urandom_range(0, 6));
    endcase
    return c;
  endfunction

  // settings after reset, points past the end of the scan are dropped
  task automatic test_reset_settings();
    send_point(16'd0, 12'd0);
    send_point(16'hFFFF, 12'd1);
    send_point(16'd300, 12'd5);
    send_point(16'd1234, 12'hFFF);
    send_point(16'd500, 12'd720);
    send_point(16'hFFFF, 12'd719);
    settle();
  endtask

  // extreme angles and limits, a six-point scan and a one-point scan
  task automatic test_extreme_angles();
    program_all(make_cfg(16'h8000, 16'h7FFF, 13'd6, 13'd3, 16'd0, 16'd0, 13'd2));
    send_point(16'hFFFF, 12'd0);
    send_point(16'd0, 12'd1);
    send_point(16'hFFFF, 12'd2);
    send_point(16'd1, 12'd3);
    send_point(16'd40000, 12'd4);
    send_point(16'hFFFF, 12'd5);
    settle();
    program_all(make_cfg(16'h7FFF, 16'h8000, 13'd1, 13'd0, 16'hFFFF, 16'hFFFF, 13'd0));
    send_point(16'hFFFF, 12'd0);
    send_point(16'd0, 12'd0);
    settle();
  endtask

  // zero-length scan never completes
  task automatic test_empty_scan();
    program_all(make_cfg(16'd0, 16'd91, 13'd0, 13'd10, 16'd250, 16'd400, 13'd3));
    send_point(16'd100, 12'd0);
    send_point(16'hFFFF, 12'hFFF);
    send_point(16'd7, 12'd1);
    settle();
  endtask

  // write to an index past the map leaves the settings alone
  task automatic test_unknown_register();
    program_all(make_cfg(16'h4000, 16'h1000, 13'd3, 13'd2, 16'd1000, 16'd1000, 13'd1));
    write_one(NO_SUCH_REG, 16'hFFFF);
    send_point(16'd500, 12'd0);
    send_point(16'd600, 12'd1);
    send_point(16'd700, 12'd2);
    settle();
  endtask

  // settings change halfway through a scan, counters carry over
  task automatic test_mid_scan_write();
    program_all(make_cfg(16'hC000, 16'h2000, 13'd8, 13'd3, 16'd200, 16'd300, 13'd1));
    send_point(16'd150, 12'd0);
    send_point(16'd900, 12'd1);
    send_point(16'd250, 12'd2);
    send_point(16'd50, 12'd3);
    settle();
    write_one(lszof_pkg::REG_LATERAL_LIMIT, 16'hFFFF);
    write_one(lszof_pkg::REG_SIDE_COUNT_MIN, 16'd2);
    send_point(16'd120, 12'd4);
    send_point(16'd3000, 12'd5);
    send_point(16'd80, 12'd6);
    send_point(16'd10, 12'd7);
    settle();
  endtask

  // random settings, mostly whole scans with dropped, repeated and stray points
  task automatic test_random_scans();
    int              phase;
    int              p;
    int              roll;
    lszof_pkg::cfg_t c;
    phase = 0;
    counted_points = 0;
    while (counted_points < RANDOM_POINTS) begin
      calm = (phase >= 6 && phase < 10);
      c = random_cfg();
      program_all(c);
      p = (c.scan_points < lszof_pkg::MAX_POINTS) ? c.scan_points : lszof_pkg::MAX_POINTS;
      if (p > 64) begin
        repeat ($urandom_range(15, 40)) begin
          roll = $urandom_range(0, 99);
          if (roll < 70) begin
            send_point(random_range(), 12'($urandom_range(0, p - 1)));
          end else if (roll < 90) begin
            send_point(random_range(), 12'($urandom()));
          end else begin
            send_point(random_range(), 12'(p - 1));
          end
        end
      end else begin
        repeat ($urandom_range(2, 6)) begin
          for (int i = 0; i < p; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
              send_point(random_range(), 12'($urandom()));
            end
            if (roll < 5 || roll >= 8) begin
              send_point(random_range(), 12'(i));
            end
            if (roll >= 8 && roll < 11) begin
              send_point(random_range(), 12'(i));
            end
          end
        end
      end
      settle();
      phase++;
    end
    calm = 1'b0;
  endtask

  initial begin
    build_sine_lut();
    live_cfg = make_cfg(16'hC000, 16'd91, 13'd720, 13'd10, 16'd250, 16'd400, 13'd3);
    left_hits  = 0;
    right_hits = 0;
    front_hits = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_extreme_angles();
    test_empty_scan();
    test_unknown_register();
    test_mid_scan_write();
    test_random_scans();
    while (expected_flags.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
